@@ hw/rtl/cpu_duty_throttle_macros.svh @@
// ----------------------------------------------------------------------------
// cpu_duty_throttle assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CPU_DUTY_THROTTLE_MACROS_SVH
`define CPU_DUTY_THROTTLE_MACROS_SVH

// Same-cycle implication
`define CDT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CDT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cdt_pkg.sv @@
// ----------------------------------------------------------------------------
// cdt_pkg
// Types and constants shared by the duty-cycle throttle modules.
// ----------------------------------------------------------------------------
package cdt_pkg;

  // Opcodes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_RATION     = 2'd0;
  localparam logic [1:0] REG_CORE_COUNT = 2'd1;
  localparam logic [1:0] REG_SLEEP_CAP  = 2'd2;

  // Configuration reset values
  localparam logic [9:0]  RATION_RST     = 10'd1;
  localparam logic [8:0]  CORE_COUNT_RST = 9'd4;
  localparam logic [23:0] SLEEP_CAP_RST  = 24'd1000000;

  // Thousandths in a full share
  localparam logic [9:0] FULL_SHARE = 10'd1000;

  // Divider operand select
  localparam logic DIV_SCALE = 1'b0;
  localparam logic DIV_SLEEP = 1'b1;

  typedef struct packed {
    logic ld_in;      // capture input transaction
    logic div_start;  // launch divider
    logic div_sel;    // divider operands
    logic ld_busy;    // capture scaled busy time
    logic ld_diff;    // capture elapsed and use
    logic ld_prod;    // capture threshold products
    logic ld_sleep;   // capture sleep from quotient
    logic clr_sleep;  // no sleep this tick
    logic commit;     // update state and load output register
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       div_busy;
    logic       div_done;
    logic       need_div;
  } sts_t;

endpackage

@@ hw/rtl/cdt_divider.sv @@
// ----------------------------------------------------------------------------
// cdt_divider
// Restoring divider, two quotient bits per cycle, 10-bit divisor.
// ----------------------------------------------------------------------------
module cdt_divider #(
  parameter int WIDTH = 58
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [9:0]       divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o
);

  localparam int STEPS = WIDTH / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [WIDTH-1:0] shr_q, shr_d;
  logic [9:0]       rem_q, rem_d;
  logic [9:0]       den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [10:0] t1, t2;
  logic        ge1, ge2;
  logic [9:0]  r1, r2;

  always_comb begin
    t1 = {rem_q, shr_q[WIDTH-1]};
    ge1 = t1 >= {1'b0, den_q};
    r1 = ge1 ? 10'(t1 - {1'b0, den_q}) : t1[9:0];
    t2 = {r1, shr_q[WIDTH-2]};
    ge2 = t2 >= {1'b0, den_q};
    r2 = ge2 ? 10'(t2 - {1'b0, den_q}) : t2[9:0];
  end

  always_comb begin
    shr_d  = shr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      shr_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      shr_d = {shr_q[WIDTH-3:0], ge1, ge2};
      rem_d = r2;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shr_q <= shr_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = shr_q;

endmodule

@@ hw/rtl/cdt_datapath.sv @@
// ----------------------------------------------------------------------------
// cdt_datapath
// Configuration, period state, threshold arithmetic and result register.
// ----------------------------------------------------------------------------
module cdt_datapath #(
  parameter int TIME_BITS = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cdt_pkg::cmd_t cmd_i,
  output cdt_pkg::sts_t sts_o,
  input  logic [1:0]    in_op_i,
  input  logic [47:0]   in_wall_i,
  input  logic [47:0]   in_busy_i,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [23:0]   cfg_data_i,
  output logic [23:0]   out_sleep_o,
  output logic          out_valid_o,
  output logic [47:0]   out_wall_o,
  output logic [47:0]   out_busy_o
);

  localparam int W     = TIME_BITS;
  localparam int PW    = TIME_BITS + 10;
  localparam int RAW_W = (PW > 48) ? PW : 48;
  localparam int DIV_W = RAW_W + (RAW_W % 2);

  // configuration
  logic [9:0]  ration_q;
  logic [8:0]  core_count_q;
  logic [23:0] sleep_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ration_q     <= cdt_pkg::RATION_RST;
      core_count_q <= cdt_pkg::CORE_COUNT_RST;
      sleep_cap_q  <= cdt_pkg::SLEEP_CAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cdt_pkg::REG_RATION:     ration_q     <= cfg_data_i[9:0];
        cdt_pkg::REG_CORE_COUNT: core_count_q <= cfg_data_i[8:0];
        cdt_pkg::REG_SLEEP_CAP:  sleep_cap_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [9:0] ra_eff;
  logic [9:0] cores_eff;
  logic       throttle_off;

  assign ra_eff       = (ration_q == '0) ? 10'd1 : ration_q;
  assign cores_eff    = (core_count_q == '0) ? 10'd1 : {1'b0, core_count_q};
  assign throttle_off = ration_q >= cdt_pkg::FULL_SHARE;

  // working registers
  logic [1:0]   op_q;
  logic [W-1:0] wall_q;
  logic [47:0]  raw_q;
  logic [W-1:0] busy_q;
  logic [W-1:0] elapsed_q;
  logic [W-1:0] use_q;
  logic [PW-1:0] prod_e_q;
  logic [PW-1:0] prod_u_q;
  logic [23:0]  sleep_q;

  // period state
  logic [W-1:0] pws_q, pbs_q, wall_total_q, busy_total_q;

  // divider
  logic [DIV_W-1:0] div_dividend;
  logic [9:0]       div_divisor;
  logic [DIV_W-1:0] quot;
  logic             div_busy, div_done;

  always_comb begin
    if (cmd_i.div_sel == cdt_pkg::DIV_SLEEP) begin
      div_dividend = DIV_W'(prod_u_q);
      div_divisor  = ra_eff;
    end else begin
      div_dividend = DIV_W'(raw_q);
      div_divisor  = cores_eff;
    end
  end

  cdt_divider #(
    .WIDTH(DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // sleep from floor(use*1000/ra); saturate past 64 bits or beyond the cap
  logic [73:0] q_ext;
  logic [73:0] q_diff;
  logic        q_ovf;
  logic [23:0] sleep_calc;

  always_comb begin
    q_ext  = 74'(quot);
    q_ovf  = q_ext[73:64] != '0;
    q_diff = q_ext - 74'(elapsed_q);
    if (q_ovf || (q_diff > 74'(sleep_cap_q))) begin
      sleep_calc = sleep_cap_q;
    end else begin
      sleep_calc = q_diff[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      op_q   <= in_op_i;
      wall_q <= W'(in_wall_i);
      raw_q  <= in_busy_i;
    end
    if (cmd_i.ld_busy) begin
      busy_q <= W'(quot);
    end
    if (cmd_i.ld_diff) begin
      elapsed_q <= wall_q - pws_q;
      use_q     <= busy_q - pbs_q;
    end
    if (cmd_i.ld_prod) begin
      prod_e_q <= PW'(elapsed_q) * PW'(ra_eff);
      prod_u_q <= PW'(use_q) * PW'(cdt_pkg::FULL_SHARE);
    end
    if (cmd_i.ld_sleep) begin
      sleep_q <= sleep_calc;
    end else if (cmd_i.clr_sleep) begin
      sleep_q <= '0;
    end
  end

  // state update and result register
  logic [W-1:0] span;
  assign span = elapsed_q + W'(sleep_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pws_q        <= '0;
      pbs_q        <= '0;
      wall_total_q <= '0;
      busy_total_q <= '0;
    end else if (cmd_i.commit) begin
      case (op_q)
        cdt_pkg::OP_START: begin
          pws_q        <= wall_q;
          pbs_q        <= busy_q;
          wall_total_q <= '0;
          busy_total_q <= '0;
        end
        cdt_pkg::OP_TICK: begin
          pws_q        <= pws_q + span;
          pbs_q        <= pbs_q + use_q;
          wall_total_q <= wall_total_q + span;
          busy_total_q <= busy_total_q + use_q;
        end
        cdt_pkg::OP_REPORT: begin
          if (wall_total_q != '0) begin
            wall_total_q <= '0;
            busy_total_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  logic        report_hit;
  logic [23:0] out_sleep_q;
  logic        out_valid_q;
  logic [47:0] out_wall_q, out_busy_q;

  assign report_hit = (op_q == cdt_pkg::OP_REPORT) && (wall_total_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_sleep_q <= (op_q == cdt_pkg::OP_TICK) ? sleep_q : '0;
      out_valid_q <= report_hit;
      out_wall_q  <= report_hit ? 48'(wall_total_q) : '0;
      out_busy_q  <= report_hit ? 48'(busy_total_q) : '0;
    end
  end

  assign out_sleep_o = out_sleep_q;
  assign out_valid_o = out_valid_q;
  assign out_wall_o  = out_wall_q;
  assign out_busy_o  = out_busy_q;

  assign sts_o.op       = op_q;
  assign sts_o.div_busy = div_busy;
  assign sts_o.div_done = div_done;
  assign sts_o.need_div = !throttle_off && (prod_u_q > prod_e_q);

endmodule

@@ hw/rtl/cdt_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdt_ctrl
// Sequencer for the throttle: handshakes, divider launches, commit.
// ----------------------------------------------------------------------------
`include "cpu_duty_throttle_macros.svh"

module cdt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  cdt_pkg::sts_t sts_i,
  output cdt_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCALE    = 3'd2;
  localparam logic [2:0] S_DIFF     = 3'd3;
  localparam logic [2:0] S_MUL      = 3'd4;
  localparam logic [2:0] S_CMP      = 3'd5;
  localparam logic [2:0] S_SLEEP    = 3'd6;
  localparam logic [2:0] S_OUT      = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = cdt_pkg::DIV_SCALE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.op) inside
          cdt_pkg::OP_START, cdt_pkg::OP_TICK: begin
            cmd_o.div_start = 1'b1;
            state_d         = S_SCALE;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_SCALE: begin
        if (sts_i.div_done) begin
          cmd_o.ld_busy = 1'b1;
          state_d = (sts_i.op == cdt_pkg::OP_TICK) ? S_DIFF : S_OUT;
        end
      end
      S_DIFF: begin
        cmd_o.ld_diff = 1'b1;
        state_d       = S_MUL;
      end
      S_MUL: begin
        cmd_o.ld_prod = 1'b1;
        state_d       = S_CMP;
      end
      S_CMP: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = cdt_pkg::DIV_SLEEP;
          state_d         = S_SLEEP;
        end else begin
          cmd_o.clr_sleep = 1'b1;
          state_d         = S_OUT;
        end
      end
      S_SLEEP: begin
        if (sts_i.div_done) begin
          cmd_o.ld_sleep = 1'b1;
          state_d        = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the result register can take the new transaction
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `CDT_ASSERT_IMP(a_commit_slot_free, cmd_o.commit, (!out_valid_q || out_ready_i), "result overwritten while pending")
  `CDT_ASSERT_IMP(a_div_start_idle, cmd_o.div_start, !sts_i.div_busy, "divider launched while busy")
  `CDT_ASSERT_IMP(a_div_done_wait, sts_i.div_done, ((state_q == S_SCALE) || (state_q == S_SLEEP)), "divider finished outside a wait state")
  `CDT_ASSERT_NXT(a_accept_dispatch, (in_valid_i && in_ready_o), (state_q == S_DISPATCH), "accepted transaction not dispatched")

endmodule

@@ hw/rtl/cpu_duty_throttle.sv @@
// ----------------------------------------------------------------------------
// cpu_duty_throttle
// Duty-cycle throttle: start, tick and report opcodes over a stream channel.
// ----------------------------------------------------------------------------
// Usage: each slave transaction carries an opcode in tuser and the wall and
// raw busy times in tdata; each one yields exactly one master transaction.
// Configuration (ration, core_count, sleep_cap) is written through the cfg
// channel, which is always ready; the user must write it only while the block is idle;
// the block itself does not enforce this. Report and unused opcodes go
// straight to the commit; start runs the busy-time scaling division and
// commits; tick runs that division, the elapsed and use differences, the
// threshold products and the compare, then the sleep division when
// throttling applies (else no sleep), and commits. One transaction is in
// work at a time; one divider serves both divisions.
// The result register lets the next transaction be accepted while the last
// result still waits; a stalled receiver holds the sequencer only when a
// second result is ready. Reset clears all period state and totals and loads
// the configuration defaults; no result is pending after reset.
// ----------------------------------------------------------------------------
module cpu_duty_throttle #(
  parameter int TIME_BITS = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // slave stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [95:0]   s_axis_tdata,  // wall_time_usec[47:0], busy_time_usec[95:48]
  input  logic [1:0]    s_axis_tuser,  // opcode[1:0]
  // master stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [119:0]  m_axis_tdata,  // sleep_usec[23:0], report_wall_usec[71:24],
                                       // report_busy_usec[119:72]
  output logic [0:0]    m_axis_tuser,  // report_valid[0]
  // configuration write
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [23:0]   cfg_data_i
);

  cdt_pkg::cmd_t cmd;
  cdt_pkg::sts_t sts;

  logic [23:0] out_sleep;
  logic        out_valid;
  logic [47:0] out_wall, out_busy;

  assign cfg_ready_o = 1'b1;

  cdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cdt_datapath #(
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_op_i     (s_axis_tuser),
    .in_wall_i   (s_axis_tdata[47:0]),
    .in_busy_i   (s_axis_tdata[95:48]),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_sleep_o (out_sleep),
    .out_valid_o (out_valid),
    .out_wall_o  (out_wall),
    .out_busy_o  (out_busy)
  );

  assign m_axis_tdata = {out_busy, out_wall, out_sleep};
  assign m_axis_tuser = out_valid;

endmodule
